// ===== hw/rtl/s2c_pkg.sv =====
// ----------------------------------------------------------------------------
// s2c_pkg
// shared widths, fixed-point constants and the arctangent table function
// ----------------------------------------------------------------------------
package s2c_pkg;

    localparam int XY_W  = 43;
    localparam int Z_W   = 50;
    localparam int ANG_W = 26;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] DEG_RAD_Q46 = (PI_Q60 + 64'd1474560) / 64'd2949120;
    localparam logic [16:0] DEG_RAD_HI = DEG_RAD_Q46[40:24];
    localparam logic [23:0] DEG_RAD_LO = DEG_RAD_Q46[23:0];

    localparam logic signed [XY_W-1:0] GAIN_Q40 = 43'sh9B74EDA800;

    localparam logic signed [ANG_W-1:0] DEG360 = 26'sd23592960;
    localparam logic [24:0] DEG45  = 25'd2949120;
    localparam logic [24:0] DEG135 = 25'd8847360;
    localparam logic [24:0] DEG225 = 25'd14745600;
    localparam logic [24:0] DEG315 = 25'd20643840;
    localparam logic signed [25:0] DEG90S  = 26'sd5898240;
    localparam logic signed [25:0] DEG180S = 26'sd11796480;
    localparam logic signed [25:0] DEG270S = 26'sd17694720;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_rot;

    // shift-subtract quotient, used only while building the table
    function automatic longint div_small(input longint num, input int den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= 64'(den)) begin
                rem    = rem - 64'(den);
                quo[b] = 1'b1;
            end
        end
        return longint'(quo);
    endfunction

    function automatic longint atan_q48(input int i);
        longint acc;
        longint term;
        int     n;
        bit     neg;
        acc = 0;
        neg = 1'b0;
        if (i == 0) begin
            return longint'((PI_Q60 + 64'd8192) >> 14);
        end
        for (n = 1; n * i <= 60; n += 2) begin
            term = div_small(longint'(64'd1 << (60 - n * i)), n);
            acc  = neg ? acc - term : acc + term;
            neg  = !neg;
        end
        return (acc + 2048) >>> 12;
    endfunction

endpackage

// ===== hw/rtl/s2c_if.sv =====
// ----------------------------------------------------------------------------
// s2c interfaces
// point input channel and cartesian output channel
// ----------------------------------------------------------------------------
interface s2c_pt_if;
    logic               valid;
    logic               ready;
    logic [24:0]        right_ascension;
    logic signed [23:0] declination;
    logic [31:0]        radius;
    modport source(output valid, right_ascension, declination, radius, input ready);
    modport sink(input valid, right_ascension, declination, radius, output ready);
endinterface

interface s2c_xyz_if;
    logic               valid;
    logic               ready;
    logic signed [32:0] x_coord;
    logic signed [32:0] y_coord;
    logic signed [32:0] z_coord;
    modport source(output valid, x_coord, y_coord, z_coord, input ready);
    modport sink(input valid, x_coord, y_coord, z_coord, output ready);
endinterface

// ===== hw/rtl/spherical_to_cartesian.sv =====
// ----------------------------------------------------------------------------
// spherical_to_cartesian
// equatorial point to cartesian coordinates with two cordic cell chains
// ----------------------------------------------------------------------------
// throughput: one word per cycle while the output word is taken, set by the fully pipelined cell chain
// the whole pipeline holds when the output word is not taken
// reset clears the valid bits only; no clearing pass
module spherical_to_cartesian import s2c_pkg::*; #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    s2c_pt_if.sink    i_pt,
    s2c_xyz_if.source o_xyz
);

    localparam int LAT    = CORDIC_STAGES + 9;
    localparam int RAD_D  = CORDIC_STAGES + 7;

    logic            w_en;
    logic [LAT-1:0]  r_vld;
    logic [31:0]     r_rad [RAD_D];
    logic [1:0]      r_qra [CORDIC_STAGES];
    logic [1:0]      r_qde [CORDIC_STAGES];

    logic signed [Z_W-1:0] w_zra, w_zde;
    logic [1:0]            w_qra, w_qde;
    t_rot                  w_ra [CORDIC_STAGES + 1];
    t_rot                  w_de [CORDIC_STAGES + 1];

    logic signed [31:0] r_cra, r_sra, r_cde, r_sde;
    logic signed [31:0] n_cra, n_sra, n_cde, n_sde;
    logic signed [63:0] r_pxc, r_pys;
    logic signed [31:0] r_szp;
    logic signed [31:0] r_fx, r_fy, r_fz;
    logic signed [64:0] r_mx, r_my, r_mz;
    logic signed [32:0] r_ox, r_oy, r_oz;

    function automatic logic signed [31:0] trig_round(input logic signed [XY_W-1:0] v);
        logic signed [XY_W:0] s;
        logic signed [XY_W:0] t;
        s = (XY_W + 1)'(v) + (XY_W + 1)'(512);
        t = s >>> 10;
        if (t > (XY_W + 1)'(64'sd1073741824)) begin
            t = (XY_W + 1)'(64'sd1073741824);
        end else if (t < -(XY_W + 1)'(64'sd1073741824)) begin
            t = -(XY_W + 1)'(64'sd1073741824);
        end
        return t[31:0];
    endfunction

    function automatic logic signed [65:0] round_clamp(input logic signed [65:0] v,
                                                        input logic signed [65:0] lim);
        logic signed [65:0] t;
        t = (v + 66'sd536870912) >>> 30;
        if (t > lim) begin
            t = lim;
        end else if (t < -lim) begin
            t = -lim;
        end
        return t;
    endfunction

    assign w_en       = !r_vld[LAT-1] || o_xyz.ready;
    assign i_pt.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_pt.valid};
        end
    end

    s2c_reduce u_red_ra (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_ang  ($signed({1'b0, i_pt.right_ascension})),
        .o_z    (w_zra),
        .o_quad (w_qra)
    );

    s2c_reduce u_red_de (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_ang  (ANG_W'(i_pt.declination)),
        .o_z    (w_zde),
        .o_quad (w_qde)
    );

    assign w_ra[0] = '{x: GAIN_Q40, y: '0, z: w_zra};
    assign w_de[0] = '{x: GAIN_Q40, y: '0, z: w_zde};

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        s2c_cell #(.STAGE(g)) u_cra (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rot (w_ra[g]),
            .o_rot (w_ra[g+1])
        );
        s2c_cell #(.STAGE(g)) u_cde (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rot (w_de[g]),
            .o_rot (w_de[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rad[0] <= i_pt.radius;
            for (int k = 1; k < RAD_D; k++) begin
                r_rad[k] <= r_rad[k-1];
            end
            r_qra[0] <= w_qra;
            r_qde[0] <= w_qde;
            for (int k = 1; k < CORDIC_STAGES; k++) begin
                r_qra[k] <= r_qra[k-1];
                r_qde[k] <= r_qde[k-1];
            end
        end
    end

    // quadrant map
    always_comb begin
        logic signed [31:0] cq, sq, cd, sd;
        cq = trig_round(w_ra[CORDIC_STAGES].x);
        sq = trig_round(w_ra[CORDIC_STAGES].y);
        cd = trig_round(w_de[CORDIC_STAGES].x);
        sd = trig_round(w_de[CORDIC_STAGES].y);
        case (r_qra[CORDIC_STAGES-1])
            2'd0:    begin n_cra = cq;  n_sra = sq;  end
            2'd1:    begin n_cra = -sq; n_sra = cq;  end
            2'd2:    begin n_cra = -cq; n_sra = -sq; end
            default: begin n_cra = sq;  n_sra = -cq; end
        endcase
        case (r_qde[CORDIC_STAGES-1])
            2'd0:    begin n_cde = cd;  n_sde = sd;  end
            2'd1:    begin n_cde = -sd; n_sde = cd;  end
            2'd2:    begin n_cde = -cd; n_sde = -sd; end
            default: begin n_cde = sd;  n_sde = -cd; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        logic signed [65:0] tx, ty, tz;
        if (w_en) begin
            r_cra <= n_cra;
            r_sra <= n_sra;
            r_cde <= n_cde;
            r_sde <= n_sde;

            r_pxc <= r_cra * r_cde;
            r_pys <= r_sra * r_cde;
            r_szp <= r_sde;

            tx = round_clamp(66'(r_pxc), 66'sd1073741824);
            ty = round_clamp(66'(r_pys), 66'sd1073741824);
            r_fx <= tx[31:0];
            r_fy <= ty[31:0];
            r_fz <= r_szp;

            r_mx <= $signed({1'b0, r_rad[RAD_D-1]}) * r_fx;
            r_my <= $signed({1'b0, r_rad[RAD_D-1]}) * r_fy;
            r_mz <= $signed({1'b0, r_rad[RAD_D-1]}) * r_fz;

            tx = round_clamp(66'(r_mx), 66'sd4294967295);
            ty = round_clamp(66'(r_my), 66'sd4294967295);
            tz = round_clamp(66'(r_mz), 66'sd4294967295);
            r_ox <= tx[32:0];
            r_oy <= ty[32:0];
            r_oz <= tz[32:0];
        end
    end

    assign o_xyz.valid   = r_vld[LAT-1];
    assign o_xyz.x_coord = r_ox;
    assign o_xyz.y_coord = r_oy;
    assign o_xyz.z_coord = r_oz;

endmodule

// ===== hw/rtl/s2c_reduce.sv =====
// ----------------------------------------------------------------------------
// s2c_reduce
// angle reduction to a quadrant and conversion of the residual to radians
// ----------------------------------------------------------------------------
module s2c_reduce import s2c_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [ANG_W-1:0] i_ang,
    output logic signed [Z_W-1:0]   o_z,
    output logic [1:0]              o_quad
);

    logic [24:0]        r_a;
    logic [24:0]        n_a;
    logic signed [25:0] w_a;
    logic signed [23:0] r_res;
    logic signed [23:0] n_res;
    logic [1:0]         r_q1, r_q2, r_q3;
    logic [1:0]         n_q1;
    logic signed [41:0] r_phi;
    logic signed [48:0] r_plo;
    logic signed [65:0] w_sum;
    logic signed [Z_W-1:0] r_z;

    always_comb begin
        if (i_ang < 0) begin
            w_a = i_ang + DEG360;
        end else if (i_ang >= DEG360) begin
            w_a = i_ang - DEG360;
        end else begin
            w_a = i_ang;
        end
        n_a = w_a[24:0];
    end

    always_comb begin
        if (r_a < DEG45) begin
            n_q1  = 2'd0;
            n_res = 24'($signed({1'b0, r_a}));
        end else if (r_a < DEG135) begin
            n_q1  = 2'd1;
            n_res = 24'($signed({1'b0, r_a}) - DEG90S);
        end else if (r_a < DEG225) begin
            n_q1  = 2'd2;
            n_res = 24'($signed({1'b0, r_a}) - DEG180S);
        end else if (r_a < DEG315) begin
            n_q1  = 2'd3;
            n_res = 24'($signed({1'b0, r_a}) - DEG270S);
        end else begin
            n_q1  = 2'd0;
            n_res = 24'($signed({1'b0, r_a}) - DEG360);
        end
    end

    assign w_sum = $signed({r_phi, 24'd0}) + 66'(r_plo) + 66'sd8192;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= n_a;
            r_res <= n_res;
            r_q1  <= n_q1;
            r_phi <= r_res * $signed({1'b0, DEG_RAD_HI});
            r_plo <= r_res * $signed({1'b0, DEG_RAD_LO});
            r_q2  <= r_q1;
            r_z   <= w_sum[63:14];
            r_q3  <= r_q2;
        end
    end

    assign o_z    = r_z;
    assign o_quad = r_q3;

endmodule

// ===== hw/rtl/s2c_cell.sv =====
// ----------------------------------------------------------------------------
// s2c_cell
// one cordic rotation step, registered
// ----------------------------------------------------------------------------
module s2c_cell import s2c_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_rot i_rot,
    output t_rot o_rot
);

    localparam longint ATAN_L = atan_q48(STAGE);
    localparam logic signed [Z_W-1:0] ATAN = ATAN_L[Z_W-1:0];

    t_rot r_rot;
    t_rot n_rot;
    logic signed [XY_W-1:0] w_dx;
    logic signed [XY_W-1:0] w_dy;

    assign w_dx = i_rot.y >>> STAGE;
    assign w_dy = i_rot.x >>> STAGE;

    always_comb begin
        if (!i_rot.z[Z_W-1]) begin
            n_rot.x = i_rot.x - w_dx;
            n_rot.y = i_rot.y + w_dy;
            n_rot.z = i_rot.z - ATAN;
        end else begin
            n_rot.x = i_rot.x + w_dx;
            n_rot.y = i_rot.y - w_dy;
            n_rot.z = i_rot.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
        end
    end

    assign o_rot = r_rot;

endmodule
